@@ hw/rtl/rpn_stack_calculator_with_variables_assert.svh @@
// ----------------------------------------------------------------------------
// RPN calculator assertion macros
// Wrappers for the concurrent checks used in the calculator top level. They
// expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_WITH_VARIABLES_ASSERT_SVH
`define RPN_STACK_CALCULATOR_WITH_VARIABLES_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define RPN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge of clk outside reset.
`define RPN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RPN_ASSERT_IMP(lbl, ante, cons, msg)
`define RPN_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/rpn_calc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared widths, command and result codes, and the stack control structs.
// ----------------------------------------------------------------------------
package rpn_calc_pkg;

    localparam int DATA_W          = 32;
    localparam int NUM_VARS        = 26;
    localparam int VAR_W           = 5;
    localparam int STACK_DEPTH_DEF = 26;

    localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [63:0]       Q_HALF = 64'h0000_0000_0000_8000;

    typedef enum logic [3:0] {
        CMD_NUM    = 4'd0,
        CMD_VAR    = 4'd1,
        CMD_ASSIGN = 4'd2,
        CMD_ADD    = 4'd3,
        CMD_SUB    = 4'd4,
        CMD_MUL    = 4'd5,
        CMD_SHOW   = 4'd6,
        CMD_LIST   = 4'd7,
        CMD_LAST   = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_VAR  = 3'd0,
        KIND_TOP  = 3'd1,
        KIND_LAST = 3'd2,
        KIND_LIST = 3'd3,
        KIND_OVF  = 3'd4,
        KIND_UNF  = 3'd5
    } kind_t;

    // Shift command for the stack cells. Push and pop are never both set.
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stk_stat_t;

endpackage

@@ hw/rtl/rpn_calc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator stack cell
// Holds one stack entry; takes its upper neighbor's value on a push and its
// lower neighbor's value on a pop.
// ----------------------------------------------------------------------------
module rpn_calc_cell (
    input  logic                             clk,
    input  rpn_calc_pkg::stk_ctrl_t          ctrl,
    input  logic [rpn_calc_pkg::DATA_W-1:0]  above,
    input  logic [rpn_calc_pkg::DATA_W-1:0]  below,
    output logic [rpn_calc_pkg::DATA_W-1:0]  q
);

    logic [rpn_calc_pkg::DATA_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            q_reg <= above;
        end
        else if (ctrl.pop)
        begin
            q_reg <= below;
        end
    end

    assign q = q_reg;

endmodule

@@ hw/rtl/rpn_calc_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator value stack
// A chain of cells with the top of stack in cell zero, plus the fill count.
// ----------------------------------------------------------------------------
module rpn_calc_stack #(
    parameter int DEPTH = rpn_calc_pkg::STACK_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rpn_calc_pkg::stk_ctrl_t          ctrl,
    input  logic [rpn_calc_pkg::DATA_W-1:0]  push_data,
    output logic [rpn_calc_pkg::DATA_W-1:0]  top,
    output rpn_calc_pkg::stk_stat_t          stat
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [rpn_calc_pkg::DATA_W-1:0] cell_q [DEPTH];
    logic [CW-1:0]                   count_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [rpn_calc_pkg::DATA_W-1:0] above_d;
            logic [rpn_calc_pkg::DATA_W-1:0] below_d;

            if (g == 0)
            begin : g_head
                assign above_d = push_data;
            end
            else
            begin : g_body
                assign above_d = cell_q[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign below_d = '0;
            end
            else
            begin : g_link
                assign below_d = cell_q[g+1];
            end

            rpn_calc_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .above (above_d),
                .below (below_d),
                .q     (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.push)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (ctrl.pop)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    assign top        = cell_q[0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));

endmodule

@@ hw/rtl/rpn_stack_calculator_with_variables.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator with variables
// This block takes one token per request and works it one at a time. A push
// goes onto the stack; a variable is read, shown and pushed, or popped and
// stored if never assigned; add, subtract and multiply pop two operands and
// push the result (the 32x32 product and its rounding each get a register
// stage); show top and last report one result; a list walks the 26-entry
// variable memory letter by letter through its single registered read port,
// reads and reports each nonzero variable, and holds while the output stalls.
// The stack is a chain of shift cells with the top of stack in cell zero.
// Values are Q16.16; add, subtract and multiply saturate, and multiply rounds
// half up. Every token that reports anything marks its final result with last_of_run.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_with_variables_assert.svh"

module rpn_stack_calculator_with_variables #(
    parameter int STACK_DEPTH = rpn_calc_pkg::STACK_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Token requests.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3:0]                          cmd,
    input  logic signed [rpn_calc_pkg::DATA_W-1:0] operand,
    input  logic [rpn_calc_pkg::VAR_W-1:0]      letter,
    // Result requests.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          kind,
    output logic signed [rpn_calc_pkg::DATA_W-1:0] result_value,
    output logic [rpn_calc_pkg::VAR_W-1:0]      result_letter,
    output logic                                last_of_run
);

    localparam int NV = rpn_calc_pkg::NUM_VARS;
    localparam int VW = rpn_calc_pkg::VAR_W;
    localparam int DW = rpn_calc_pkg::DATA_W;

    // Sequencer states. A token always starts in S_IDLE; pops come before
    // any store or arithmetic so that underflow reports come out in order.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_VAR_SHOW,
        S_POP1,
        S_POP2,
        S_CALC,
        S_ROUND,
        S_STORE,
        S_SHOW,
        S_LAST,
        S_LIST_RD,
        S_LIST_EM
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;

    logic [3:0]              cmd_reg;
    logic [VW-1:0]           letter_reg;
    logic [DW-1:0]           push_val_reg;
    logic signed [DW-1:0]    a_reg;
    logic signed [DW-1:0]    b_reg;
    logic signed [63:0]      prod_reg;
    logic [VW-1:0]           list_idx_reg;
    logic [NV-1:0]           assigned_reg;
    logic [NV-1:0]           nz_reg;
    logic [DW-1:0]           last_shown_reg;

    logic                    out_valid_reg;
    logic [2:0]              kind_reg;
    logic [DW-1:0]           value_reg;
    logic [VW-1:0]           rletter_reg;
    logic                    last_reg;

    // Variable memory: one write port and one registered read port. Read data
    // is only ever shown for an entry that has been written (an assigned flag or
    // a nonzero mark is needed first), so its contents before a write never show.
    logic [DW-1:0]           var_mem [NV];
    logic [DW-1:0]           rd_data_reg;
    logic                    rd_en;
    logic [VW-1:0]           rd_addr;
    logic                    wr_en;

    rpn_calc_pkg::stk_ctrl_t stk_ctrl;
    rpn_calc_pkg::stk_stat_t stk_stat;
    logic [DW-1:0]           stk_top;

    logic                    accept;
    logic                    slot_free;
    logic                    out_load;
    logic                    emit_req;
    rpn_calc_pkg::kind_t     emit_kind;
    logic [DW-1:0]           emit_value;
    logic [VW-1:0]           emit_letter;
    logic                    emit_last;
    logic                    is_arith;
    logic                    letter_ok;
    logic                    idx_ok;
    logic [NV-1:0]           hi_mask;
    logic                    hi_any;

    logic [32:0]             sum_ext;
    logic [DW-1:0]           sum_sat;
    logic signed [63:0]      rnd;
    logic signed [63:0]      shf;
    logic [DW-1:0]           mul_sat;

    rpn_calc_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (stk_ctrl),
        .push_data (push_val_reg),
        .top       (stk_top),
        .stat      (stk_stat)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = emit_req && slot_free;
    assign letter_ok = (letter < VW'(NV));
    assign idx_ok    = (list_idx_reg < VW'(NV));
    assign is_arith  = (cmd_reg == rpn_calc_pkg::CMD_ADD) ||
                       (cmd_reg == rpn_calc_pkg::CMD_SUB) ||
                       (cmd_reg == rpn_calc_pkg::CMD_MUL);

    // Nonzero variables above the current list position decide whether the
    // listed entry is the final result of the token.
    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            hi_mask[i] = nz_reg[i] && (VW'(i) > list_idx_reg);
        end
    end
    assign hi_any = |hi_mask;

    // Saturating add and subtract on sign-extended operands.
    always_comb
    begin
        if (cmd_reg == rpn_calc_pkg::CMD_SUB)
        begin
            sum_ext = {a_reg[DW-1], a_reg} - {b_reg[DW-1], b_reg};
        end
        else
        begin
            sum_ext = {a_reg[DW-1], a_reg} + {b_reg[DW-1], b_reg};
        end

        if (sum_ext[32] != sum_ext[31])
        begin
            sum_sat = sum_ext[32] ? rpn_calc_pkg::Q_MIN : rpn_calc_pkg::Q_MAX;
        end
        else
        begin
            sum_sat = sum_ext[31:0];
        end
    end

    // Round half up and drop 16 fraction bits; the arithmetic shift floors.
    always_comb
    begin
        rnd = prod_reg + $signed(rpn_calc_pkg::Q_HALF);
        shf = rnd >>> 16;
        if ((&shf[63:31]) || !(|shf[63:31]))
        begin
            mul_sat = shf[31:0];
        end
        else
        begin
            mul_sat = shf[63] ? rpn_calc_pkg::Q_MIN : rpn_calc_pkg::Q_MAX;
        end
    end

    // Sequencer decode: next state, stack shifts, memory ports and the
    // result that this state wants to report.
    always_comb
    begin
        state_next  = state_reg;
        stk_ctrl    = '0;
        rd_en       = 1'b0;
        rd_addr     = list_idx_reg;
        wr_en       = 1'b0;
        emit_req    = 1'b0;
        emit_kind   = rpn_calc_pkg::KIND_VAR;
        emit_value  = '0;
        emit_letter = '0;
        emit_last   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        rpn_calc_pkg::CMD_NUM:
                        begin
                            state_next = S_PUSH;
                        end
                        rpn_calc_pkg::CMD_VAR:
                        begin
                            if (letter_ok)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = letter;
                                state_next = assigned_reg[letter] ? S_VAR_SHOW : S_POP1;
                            end
                        end
                        rpn_calc_pkg::CMD_ASSIGN:
                        begin
                            if (letter_ok)
                            begin
                                state_next = S_POP1;
                            end
                        end
                        rpn_calc_pkg::CMD_ADD, rpn_calc_pkg::CMD_SUB,
                        rpn_calc_pkg::CMD_MUL:
                        begin
                            state_next = S_POP1;
                        end
                        rpn_calc_pkg::CMD_SHOW:
                        begin
                            state_next = S_SHOW;
                        end
                        rpn_calc_pkg::CMD_LIST:
                        begin
                            state_next = S_LIST_RD;
                        end
                        rpn_calc_pkg::CMD_LAST:
                        begin
                            state_next = S_LAST;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_PUSH:
            begin
                if (stk_stat.full)
                begin
                    emit_req  = 1'b1;
                    emit_kind = rpn_calc_pkg::KIND_OVF;
                    emit_last = 1'b1;
                    if (slot_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    stk_ctrl.push = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_VAR_SHOW:
            begin
                emit_req    = 1'b1;
                emit_kind   = rpn_calc_pkg::KIND_VAR;
                emit_value  = rd_data_reg;
                emit_letter = letter_reg;
                emit_last   = !stk_stat.full;
                if (slot_free)
                begin
                    state_next = S_PUSH;
                end
            end

            S_POP1:
            begin
                if (stk_stat.empty)
                begin
                    emit_req  = 1'b1;
                    emit_kind = rpn_calc_pkg::KIND_UNF;
                end
                else
                begin
                    stk_ctrl.pop = 1'b1;
                end
                if (!stk_stat.empty || slot_free)
                begin
                    state_next = is_arith ? S_POP2 : S_STORE;
                end
            end

            S_POP2:
            begin
                if (stk_stat.empty)
                begin
                    emit_req  = 1'b1;
                    emit_kind = rpn_calc_pkg::KIND_UNF;
                    emit_last = 1'b1;
                end
                else
                begin
                    stk_ctrl.pop = 1'b1;
                end
                if (!stk_stat.empty || slot_free)
                begin
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                state_next = (cmd_reg == rpn_calc_pkg::CMD_MUL) ? S_ROUND : S_PUSH;
            end

            S_ROUND:
            begin
                state_next = S_PUSH;
            end

            S_STORE:
            begin
                emit_req    = 1'b1;
                emit_kind   = rpn_calc_pkg::KIND_VAR;
                emit_value  = b_reg;
                emit_letter = letter_reg;
                emit_last   = 1'b1;
                if (slot_free)
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SHOW:
            begin
                emit_req  = 1'b1;
                emit_last = 1'b1;
                if (stk_stat.empty)
                begin
                    emit_kind = rpn_calc_pkg::KIND_UNF;
                end
                else
                begin
                    emit_kind  = rpn_calc_pkg::KIND_TOP;
                    emit_value = stk_top;
                end
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            S_LAST:
            begin
                emit_req   = 1'b1;
                emit_kind  = rpn_calc_pkg::KIND_LAST;
                emit_value = last_shown_reg;
                emit_last  = 1'b1;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            S_LIST_RD:
            begin
                if (!idx_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (nz_reg[list_idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = S_LIST_EM;
                end
            end

            S_LIST_EM:
            begin
                emit_req    = 1'b1;
                emit_kind   = rpn_calc_pkg::KIND_LIST;
                emit_value  = rd_data_reg;
                emit_letter = list_idx_reg;
                emit_last   = !hi_any;
                if (slot_free)
                begin
                    state_next = S_LIST_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, datapath and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            letter_reg     <= '0;
            push_val_reg   <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            prod_reg       <= '0;
            list_idx_reg   <= '0;
            assigned_reg   <= '0;
            nz_reg         <= '0;
            last_shown_reg <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= '0;
            value_reg      <= '0;
            rletter_reg    <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                cmd_reg      <= cmd;
                letter_reg   <= letter;
                push_val_reg <= operand;
                list_idx_reg <= '0;
            end

            unique case (state_reg)
                S_VAR_SHOW:
                begin
                    push_val_reg <= rd_data_reg;
                end
                S_POP1:
                begin
                    b_reg <= stk_stat.empty ? '0 : stk_top;
                end
                S_POP2:
                begin
                    a_reg <= stk_stat.empty ? '0 : stk_top;
                end
                S_CALC:
                begin
                    prod_reg     <= a_reg * b_reg;
                    push_val_reg <= sum_sat;
                end
                S_ROUND:
                begin
                    push_val_reg <= mul_sat;
                end
                S_STORE:
                begin
                    if (wr_en)
                    begin
                        nz_reg[letter_reg] <= (b_reg != '0);
                        if (cmd_reg == rpn_calc_pkg::CMD_VAR)
                        begin
                            assigned_reg[letter_reg] <= 1'b1;
                        end
                    end
                end
                S_SHOW:
                begin
                    if (slot_free && !stk_stat.empty)
                    begin
                        last_shown_reg <= stk_top;
                    end
                end
                S_LIST_RD:
                begin
                    if (idx_ok && !nz_reg[list_idx_reg])
                    begin
                        list_idx_reg <= list_idx_reg + VW'(1);
                    end
                end
                S_LIST_EM:
                begin
                    if (slot_free)
                    begin
                        list_idx_reg <= list_idx_reg + VW'(1);
                    end
                end
                default:
                begin
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= emit_kind;
                value_reg     <= emit_value;
                rletter_reg   <= emit_letter;
                last_reg      <= emit_last;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Variable memory ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            var_mem[letter_reg] <= b_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= var_mem[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign result_value  = value_reg;
    assign result_letter = rletter_reg;
    assign last_of_run   = last_reg;

    // Checks on the sequencer, the stack control and the result hold.
    `RPN_ASSERT_IMP(a_push_pop_excl, stk_ctrl.push, !stk_ctrl.pop, "push and pop together")
    `RPN_ASSERT_IMP(a_no_push_full, stk_ctrl.push, !stk_stat.full, "push into a full stack")
    `RPN_ASSERT_IMP(a_wr_letter_ok, wr_en, letter_reg < VW'(NV), "variable write out of range")
    `RPN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(kind), "result changed while stalled")

endmodule
